// ===== rtl/core/fpc_pkg.sv =====
// Shared types and constants for the single/half float format converter.
// No dependencies; imported by every module in rtl/core.
package fpc_pkg;

	// Direction of conversion, carried with each word
	typedef enum logic {
		CMD_S2H = 1'b0,
		CMD_H2S = 1'b1
	} cmd_t;

	// Single-to-half thresholds, compared against the 31-bit magnitude
	localparam logic [30:0] S_INF_MAG      = 31'h7f800000;
	localparam logic [30:0] S_OVF_MAG      = 31'h477fefff;
	localparam logic [30:0] S_UNF_MAG      = 31'h33000001;
	localparam logic [7:0]  S2H_EXP_BIAS   = 8'h70;
	localparam logic [7:0]  S2H_SUB_SHIFT  = 8'h7e;
	localparam logic [4:0]  S2H_NORM_SHIFT = 5'd13;

	// Half results for special operands
	localparam logic [14:0] H_QNAN = 15'h7fff;
	localparam logic [14:0] H_INF  = 15'h7c00;

	// Half-to-single constants
	localparam logic [4:0]  H_EXP_MAX      = 5'h1f;
	localparam logic [7:0]  H2S_EXP_BIAS   = 8'h70;
	localparam logic [7:0]  S_EXP_MAX      = 8'hff;
	localparam logic [31:0] S_QNAN         = 32'h7fffffff;

endpackage

// ===== rtl/core/fpc_s2h.sv =====
// Single to half conversion with round to nearest even, combinational.
// Depends on fpc_pkg.
module fpc_s2h import fpc_pkg::*; (
	input  logic [31:0] single_in,
	output logic [15:0] half_out
);

	logic        sgn;
	logic [30:0] mag;
	logic [7:0]  exp8;
	logic        is_norm;
	logic [23:0] man24;
	logic [4:0]  sh;
	logic [4:0]  sh_m1;
	logic [23:0] guard_vec;
	logic [23:0] sticky_mask;
	logic        guard;
	logic        sticky;
	logic [9:0]  trunc;
	logic        round_up;
	logic [4:0]  exp5;
	logic [14:0] body;

	assign sgn  = single_in[31];
	assign mag  = single_in[30:0];
	assign exp8 = mag[30:23];

	// Normal halves drop 13 bits; subnormals shift further with hidden bit
	assign is_norm = exp8 > S2H_EXP_BIAS;
	assign man24   = {~is_norm, mag[22:0]};
	assign sh      = is_norm ? S2H_NORM_SHIFT : 5'(S2H_SUB_SHIFT - exp8);
	assign sh_m1   = sh - 5'd1;
	assign exp5    = is_norm ? 5'(exp8 - S2H_EXP_BIAS) : 5'd0;

	// Guard and sticky bits for nearest-even rounding
	assign guard_vec   = man24 >> sh_m1;
	assign guard       = guard_vec[0];
	assign sticky_mask = (24'd1 << sh_m1) - 24'd1;
	assign sticky      = |(man24 & sticky_mask);
	assign trunc       = 10'(man24 >> sh);
	assign round_up    = guard & (sticky | trunc[0]);

	// A mantissa carry ripples into the exponent field naturally
	assign body = {exp5, trunc} + 15'(round_up);

	// Special cases take priority over the rounded value
	always_comb begin
		priority if (mag > S_INF_MAG) begin
			half_out = {1'b0, H_QNAN};
		end else if (mag > S_OVF_MAG) begin
			half_out = {sgn, H_INF};
		end else if (mag < S_UNF_MAG) begin
			half_out = {sgn, 15'd0};
		end else begin
			half_out = {sgn, body};
		end
	end

endmodule

// ===== rtl/core/fpc_h2s.sv =====
// Half to single conversion, exact, with subnormal normalisation.
// Depends on fpc_pkg.
module fpc_h2s import fpc_pkg::*; (
	input  logic [15:0] half_in,
	output logic [31:0] single_out
);

	logic       sgn;
	logic [4:0] exp5;
	logic [9:0] man10;
	logic [3:0] lz;
	logic [3:0] shift;
	logic [9:0] norm_man;
	logic [7:0] norm_exp;

	// Leading-zero count over the 10-bit half mantissa
	function automatic logic [3:0] lead_zeros(input logic [9:0] v);
		logic [3:0] n;
		logic       found;
		n     = 4'd10;
		found = 1'b0;
		for (int i = 9; i >= 0; i--) begin
			if (!found && v[i]) begin
				n     = 4'(9 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	assign sgn   = half_in[15];
	assign exp5  = half_in[14:10];
	assign man10 = half_in[9:0];

	// Subnormal: shift out the leading one, exponent drops by the leading-zero count
	assign lz       = lead_zeros(man10);
	assign shift    = lz + 4'd1;
	assign norm_man = 10'(man10 << shift);
	assign norm_exp = H2S_EXP_BIAS - 8'(lz);

	always_comb begin
		priority if (exp5 == H_EXP_MAX) begin
			if (man10 != 10'd0) begin
				single_out = S_QNAN;
			end else begin
				single_out = {sgn, S_EXP_MAX, 23'd0};
			end
		end else if (exp5 == 5'd0) begin
			if (man10 != 10'd0) begin
				single_out = {sgn, norm_exp, norm_man, 13'd0};
			end else begin
				single_out = {sgn, 31'd0};
			end
		end else begin
			single_out = {sgn, 8'(exp5) + H2S_EXP_BIAS, man10, 13'd0};
		end
	end

endmodule

// ===== rtl/core/fp32_fp16_converter_top.sv =====
// Single/half IEEE float converter, rounding to nearest even into half.
// A word is taken whenever start is high (busy is always low); its result
// appears on result with done high for one cycle, once it has passed the
// input register, one pass of conversion logic and the result register.
// One word per cycle. The receiver cannot stall, so the result must be
// captured in the cycle done is high.
// Depends on fpc_pkg, fpc_s2h, fpc_h2s.
module fp32_fp16_converter_top import fpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] operand,
	output logic        done,
	output logic [31:0] result
);

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [31:0] operand_s1;
	logic        valid_s2;
	logic [31:0] result_s2;
	logic [15:0] half_res;
	logic [31:0] single_res;
	logic [31:0] conv_res;

	// Never stalls: a new word can be taken every cycle
	assign busy = 1'b0;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			cmd_s1     <= cmd_t'(command);
			operand_s1 <= operand;
		end
	end

	// Both directions in parallel, pick by command
	fpc_s2h u_s2h (
		.single_in (operand_s1),
		.half_out  (half_res)
	);

	fpc_h2s u_h2s (
		.half_in    (operand_s1[15:0]),
		.single_out (single_res)
	);

	always_comb begin
		unique case (cmd_s1)
			CMD_S2H: conv_res = {16'd0, half_res};
			CMD_H2S: conv_res = single_res;
			default: conv_res = {16'd0, half_res};
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= conv_res;
		end
	end

	assign done   = valid_s2;
	assign result = result_s2;

endmodule
